[rtl/cces_pkg.sv]
// ============================================================================
// cces_pkg: shared types and constants of the carbon compartment Euler step
// Holds number formats, operation codes, register and pool indexes, and the
// command bundle that the controller sends to the datapath.
// ============================================================================
package cces_pkg;

    // Number formats.
    localparam int FRACTION_BITS = 24;
    localparam int COEF_W        = 32;
    localparam int WIDE_W        = 64;
    localparam int POOL_W        = 48;
    localparam int TOTAL_W       = 51;
    localparam int COUNT_W       = 32;
    localparam int CFG_W         = 64;

    // Sequencing.
    localparam int NUM_POOLS = 7;
    localparam int NUM_OPS   = 20;
    localparam int CNT_W     = 6;
    localparam int RUN_LAST  = 2 * NUM_OPS + 1;

    typedef logic [4:0] op_t;
    typedef logic [2:0] pool_idx_t;
    typedef logic [2:0] cfg_idx_t;

    // Multiply operations, in the order the controller issues them.
    localparam op_t OP_FLOW_LEAF   = 5'd0;
    localparam op_t OP_FLOW_BRANCH = 5'd1;
    localparam op_t OP_FLOW_STEM   = 5'd2;
    localparam op_t OP_FLOW_ROOT   = 5'd3;
    localparam op_t OP_FLOW_LITTER = 5'd4;
    localparam op_t OP_FLOW_HUMUS  = 5'd5;
    localparam op_t OP_FLOW_COAL   = 5'd6;
    localparam op_t OP_IN_LEAF     = 5'd7;
    localparam op_t OP_IN_BRANCH   = 5'd8;
    localparam op_t OP_IN_STEM     = 5'd9;
    localparam op_t OP_IN_ROOT     = 5'd10;
    localparam op_t OP_HUMIFY      = 5'd11;
    localparam op_t OP_CARBONIZE   = 5'd12;
    localparam op_t OP_UPD_LEAF    = 5'd13;
    localparam op_t OP_UPD_BRANCH  = 5'd14;
    localparam op_t OP_UPD_STEM    = 5'd15;
    localparam op_t OP_UPD_ROOT    = 5'd16;
    localparam op_t OP_UPD_LITTER  = 5'd17;
    localparam op_t OP_UPD_HUMUS   = 5'd18;
    localparam op_t OP_UPD_COAL    = 5'd19;

    // Configuration register indexes.
    localparam cfg_idx_t REG_PROD_STEP    = 3'd0;
    localparam cfg_idx_t REG_SHARE_LB     = 3'd1;
    localparam cfg_idx_t REG_SHARE_SR     = 3'd2;
    localparam cfg_idx_t REG_RELEASE_LB   = 3'd3;
    localparam cfg_idx_t REG_RELEASE_SR   = 3'd4;
    localparam cfg_idx_t REG_RELEASE_SOIL = 3'd5;
    localparam cfg_idx_t REG_COAL_HUMIFY  = 3'd6;
    localparam cfg_idx_t REG_CARBONIZE    = 3'd7;

    // Pool indexes used by the summing pass.
    localparam pool_idx_t POOL_LEAF   = 3'd0;
    localparam pool_idx_t POOL_BRANCH = 3'd1;
    localparam pool_idx_t POOL_STEM   = 3'd2;
    localparam pool_idx_t POOL_ROOT   = 3'd3;
    localparam pool_idx_t POOL_LITTER = 3'd4;
    localparam pool_idx_t POOL_HUMUS  = 3'd5;
    localparam pool_idx_t POOL_COAL   = 3'd6;

    // Command bundle from controller to datapath.
    typedef struct packed {
        logic      clear;
        logic      step_inc;
        logic      mul_en;
        logic      mul_hi;
        op_t       mul_op;
        logic      acc_add;
        logic      wb_en;
        op_t       wb_op;
        logic      sum_en;
        logic      sum_first;
        pool_idx_t sum_idx;
        logic      out_load;
    } dp_cmd_t;

endpackage

[rtl/cces_datapath.sv]
// ============================================================================
// cces_datapath: pools, coefficients and the shared multiplier
// Holds the configuration registers, the seven pools and the intermediate
// net changes, and runs the scaled products through a single 33x33 signed
// multiplier with a 97-bit accumulator.
// ============================================================================
module cces_datapath import cces_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  cfg_idx_t                  cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  dp_cmd_t                   cmd,
    output logic [COUNT_W-1:0]        step_number,
    output logic signed [POOL_W-1:0]  leaf_carbon,
    output logic signed [POOL_W-1:0]  branch_carbon,
    output logic signed [POOL_W-1:0]  stem_carbon,
    output logic signed [POOL_W-1:0]  root_carbon,
    output logic signed [POOL_W-1:0]  litter_carbon,
    output logic signed [POOL_W-1:0]  humus_carbon,
    output logic signed [POOL_W-1:0]  charcoal_carbon,
    output logic signed [TOTAL_W-1:0] total_carbon
);

    localparam int ACC_W  = 97;
    localparam int PROD_W = 66;

    localparam logic signed [WIDE_W-1:0] I64_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] I64_MIN = {1'b1, {(WIDE_W-1){1'b0}}};
    localparam logic signed [POOL_W-1:0] P48_MAX = {1'b0, {(POOL_W-1){1'b1}}};
    localparam logic signed [POOL_W-1:0] P48_MIN = {1'b1, {(POOL_W-1){1'b0}}};

    // Saturating 64-bit helpers.
    function automatic logic signed [WIDE_W-1:0] sat_add64(
        input logic signed [WIDE_W-1:0] a,
        input logic signed [WIDE_W-1:0] b
    );
        logic [WIDE_W:0] s;
        s = {a[WIDE_W-1], a} + {b[WIDE_W-1], b};
        if (s[WIDE_W] != s[WIDE_W-1])
            sat_add64 = s[WIDE_W] ? I64_MIN : I64_MAX;
        else
            sat_add64 = s[WIDE_W-1:0];
    endfunction

    function automatic logic signed [WIDE_W-1:0] sat_sub64(
        input logic signed [WIDE_W-1:0] a,
        input logic signed [WIDE_W-1:0] b
    );
        logic [WIDE_W:0] s;
        s = {a[WIDE_W-1], a} - {b[WIDE_W-1], b};
        if (s[WIDE_W] != s[WIDE_W-1])
            sat_sub64 = s[WIDE_W] ? I64_MIN : I64_MAX;
        else
            sat_sub64 = s[WIDE_W-1:0];
    endfunction

    function automatic logic signed [WIDE_W-1:0] neg_sat64(
        input logic signed [WIDE_W-1:0] a
    );
        if (a == I64_MIN)
            neg_sat64 = I64_MAX;
        else
            neg_sat64 = -a;
    endfunction

    function automatic logic signed [WIDE_W-1:0] ext_pool(
        input logic signed [POOL_W-1:0] p
    );
        ext_pool = {{(WIDE_W-POOL_W){p[POOL_W-1]}}, p};
    endfunction

    // Configuration registers.
    logic [CFG_W-1:0]  prod_step_reg;
    logic [CFG_W-1:0]  share_lb_reg;
    logic [CFG_W-1:0]  share_sr_reg;
    logic [CFG_W-1:0]  release_lb_reg;
    logic [CFG_W-1:0]  release_sr_reg;
    logic [CFG_W-1:0]  release_soil_reg;
    logic [CFG_W-1:0]  coal_humify_reg;
    logic [COEF_W-1:0] carbonize_reg;

    // Model state.
    logic signed [POOL_W-1:0] leaf_reg, branch_reg, stem_reg, root_reg;
    logic signed [POOL_W-1:0] litter_reg, humus_reg, coal_reg;
    logic [COUNT_W-1:0]       step_reg;

    // Flows and net changes of the current step.
    logic signed [WIDE_W-1:0] d_leaf_reg, d_branch_reg, d_stem_reg, d_root_reg;
    logic signed [WIDE_W-1:0] d_litter_reg, d_humus_reg, d_coal_reg;
    logic signed [WIDE_W-1:0] humus_flow_reg;

    // Multiplier pipeline.
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [TOTAL_W-1:0] total_reg;

    // Output record.
    logic [COUNT_W-1:0]        out_step_reg;
    logic signed [POOL_W-1:0]  out_leaf_reg, out_branch_reg, out_stem_reg, out_root_reg;
    logic signed [POOL_W-1:0]  out_litter_reg, out_humus_reg, out_coal_reg;
    logic signed [TOTAL_W-1:0] out_total_reg;

    logic [COEF_W-1:0]        coef;
    logic signed [WIDE_W-1:0] opnd;
    logic signed [32:0]       mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [ACC_W-1:0]  acc_shift;
    logic signed [WIDE_W-1:0] mul_res;
    logic signed [POOL_W-1:0] wb_pool;
    logic [WIDE_W:0]          upd_sum;
    logic signed [POOL_W-1:0] upd_pool;
    logic signed [POOL_W-1:0] sum_pool;

    // Configuration writes; the carbonize register keeps only its low word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_step_reg    <= '0;
            share_lb_reg     <= '0;
            share_sr_reg     <= '0;
            release_lb_reg   <= '0;
            release_sr_reg   <= '0;
            release_soil_reg <= '0;
            coal_humify_reg  <= '0;
            carbonize_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PROD_STEP:    prod_step_reg    <= cfg_data;
                REG_SHARE_LB:     share_lb_reg     <= cfg_data;
                REG_SHARE_SR:     share_sr_reg     <= cfg_data;
                REG_RELEASE_LB:   release_lb_reg   <= cfg_data;
                REG_RELEASE_SR:   release_sr_reg   <= cfg_data;
                REG_RELEASE_SOIL: release_soil_reg <= cfg_data;
                REG_COAL_HUMIFY:  coal_humify_reg  <= cfg_data;
                REG_CARBONIZE:    carbonize_reg    <= cfg_data[COEF_W-1:0];
                default:          ;
            endcase
        end
    end

    // Coefficient and operand of the product being issued.
    always_comb
    begin
        coef = prod_step_reg[CFG_W-1:COEF_W];
        opnd = '0;
        case (cmd.mul_op)
            OP_FLOW_LEAF:
            begin
                coef = release_lb_reg[COEF_W-1:0];
                opnd = ext_pool(leaf_reg);
            end
            OP_FLOW_BRANCH:
            begin
                coef = release_lb_reg[CFG_W-1:COEF_W];
                opnd = ext_pool(branch_reg);
            end
            OP_FLOW_STEM:
            begin
                coef = release_sr_reg[COEF_W-1:0];
                opnd = ext_pool(stem_reg);
            end
            OP_FLOW_ROOT:
            begin
                coef = release_sr_reg[CFG_W-1:COEF_W];
                opnd = ext_pool(root_reg);
            end
            OP_FLOW_LITTER:
            begin
                coef = release_soil_reg[COEF_W-1:0];
                opnd = ext_pool(litter_reg);
            end
            OP_FLOW_HUMUS:
            begin
                coef = release_soil_reg[CFG_W-1:COEF_W];
                opnd = ext_pool(humus_reg);
            end
            OP_FLOW_COAL:
            begin
                coef = coal_humify_reg[COEF_W-1:0];
                opnd = ext_pool(coal_reg);
            end
            OP_IN_LEAF:
            begin
                coef = share_lb_reg[COEF_W-1:0];
                opnd = {{(WIDE_W-COEF_W){1'b0}}, prod_step_reg[COEF_W-1:0]};
            end
            OP_IN_BRANCH:
            begin
                coef = share_lb_reg[CFG_W-1:COEF_W];
                opnd = {{(WIDE_W-COEF_W){1'b0}}, prod_step_reg[COEF_W-1:0]};
            end
            OP_IN_STEM:
            begin
                coef = share_sr_reg[COEF_W-1:0];
                opnd = {{(WIDE_W-COEF_W){1'b0}}, prod_step_reg[COEF_W-1:0]};
            end
            OP_IN_ROOT:
            begin
                coef = share_sr_reg[CFG_W-1:COEF_W];
                opnd = {{(WIDE_W-COEF_W){1'b0}}, prod_step_reg[COEF_W-1:0]};
            end
            OP_HUMIFY:
            begin
                coef = coal_humify_reg[CFG_W-1:COEF_W];
                opnd = d_humus_reg;
            end
            OP_CARBONIZE:
            begin
                coef = carbonize_reg;
                opnd = humus_flow_reg;
            end
            OP_UPD_LEAF:   opnd = d_leaf_reg;
            OP_UPD_BRANCH: opnd = d_branch_reg;
            OP_UPD_STEM:   opnd = d_stem_reg;
            OP_UPD_ROOT:   opnd = d_root_reg;
            OP_UPD_LITTER: opnd = d_litter_reg;
            OP_UPD_HUMUS:  opnd = d_humus_reg;
            OP_UPD_COAL:   opnd = d_coal_reg;
            default:       ;
        endcase
    end

    // The 64-bit operand goes through the multiplier as two 32-bit halves.
    assign mul_a = {1'b0, coef};
    assign mul_b = cmd.mul_hi ? {opnd[WIDE_W-1], opnd[WIDE_W-1:COEF_W]}
                              : {1'b0, opnd[COEF_W-1:0]};
    assign mul_p = mul_a * mul_b;

    // Product register and accumulator: low half loaded, high half added.
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            prod_reg <= mul_p;
        if (cmd.mul_en && cmd.mul_hi)
            acc_reg <= {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        else if (cmd.acc_add)
            acc_reg <= acc_reg + {prod_reg[ACC_W-COEF_W-1:0], {COEF_W{1'b0}}};
    end

    // Floor shift of the exact product, clamped to signed 64 bits.
    assign acc_shift = acc_reg >>> FRACTION_BITS;

    always_comb
    begin
        if ((&acc_shift[ACC_W-1:WIDE_W-1]) || !(|acc_shift[ACC_W-1:WIDE_W-1]))
            mul_res = acc_shift[WIDE_W-1:0];
        else
            mul_res = acc_shift[ACC_W-1] ? I64_MIN : I64_MAX;
    end

    // Pool that an update operation writes back, plus its saturated new value.
    always_comb
    begin
        case (cmd.wb_op)
            OP_UPD_LEAF:   wb_pool = leaf_reg;
            OP_UPD_BRANCH: wb_pool = branch_reg;
            OP_UPD_STEM:   wb_pool = stem_reg;
            OP_UPD_ROOT:   wb_pool = root_reg;
            OP_UPD_LITTER: wb_pool = litter_reg;
            OP_UPD_HUMUS:  wb_pool = humus_reg;
            OP_UPD_COAL:   wb_pool = coal_reg;
            default:       wb_pool = '0;
        endcase
        upd_sum = {{(WIDE_W-POOL_W+1){wb_pool[POOL_W-1]}}, wb_pool}
                + {mul_res[WIDE_W-1], mul_res};
        if ((&upd_sum[WIDE_W:POOL_W-1]) || !(|upd_sum[WIDE_W:POOL_W-1]))
            upd_pool = upd_sum[POOL_W-1:0];
        else
            upd_pool = upd_sum[WIDE_W] ? P48_MIN : P48_MAX;
    end

    // Write-back of pools and step count; clear zeroes the pools and step count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leaf_reg   <= '0;
            branch_reg <= '0;
            stem_reg   <= '0;
            root_reg   <= '0;
            litter_reg <= '0;
            humus_reg  <= '0;
            coal_reg   <= '0;
            step_reg   <= '0;
        end
        else if (cmd.clear)
        begin
            leaf_reg   <= '0;
            branch_reg <= '0;
            stem_reg   <= '0;
            root_reg   <= '0;
            litter_reg <= '0;
            humus_reg  <= '0;
            coal_reg   <= '0;
            step_reg   <= '0;
        end
        else
        begin
            if (cmd.step_inc)
                step_reg <= step_reg + 1'b1;
            if (cmd.wb_en)
            begin
                case (cmd.wb_op)
                    OP_UPD_LEAF:   leaf_reg   <= upd_pool;
                    OP_UPD_BRANCH: branch_reg <= upd_pool;
                    OP_UPD_STEM:   stem_reg   <= upd_pool;
                    OP_UPD_ROOT:   root_reg   <= upd_pool;
                    OP_UPD_LITTER: litter_reg <= upd_pool;
                    OP_UPD_HUMUS:  humus_reg  <= upd_pool;
                    OP_UPD_COAL:   coal_reg   <= upd_pool;
                    default:       ;
                endcase
            end
        end
    end

    // Flows are parked in the net-change registers until the inflow arrives.
    always_ff @(posedge clk)
    begin
        if (cmd.wb_en)
        begin
            case (cmd.wb_op)
                OP_FLOW_LEAF:
                begin
                    d_leaf_reg   <= mul_res;
                    d_litter_reg <= mul_res;
                end
                OP_FLOW_BRANCH:
                begin
                    d_branch_reg <= mul_res;
                    d_litter_reg <= sat_add64(d_litter_reg, mul_res);
                end
                OP_FLOW_STEM:
                begin
                    d_stem_reg   <= mul_res;
                    d_litter_reg <= sat_add64(d_litter_reg, mul_res);
                end
                OP_FLOW_ROOT:
                begin
                    d_root_reg  <= mul_res;
                    d_humus_reg <= mul_res;
                end
                OP_FLOW_LITTER:
                begin
                    d_litter_reg <= sat_add64(d_litter_reg, neg_sat64(mul_res));
                    d_humus_reg  <= sat_add64(d_humus_reg, mul_res);
                end
                OP_FLOW_HUMUS:  humus_flow_reg <= mul_res;
                OP_FLOW_COAL:   d_coal_reg     <= mul_res;
                OP_IN_LEAF:     d_leaf_reg     <= sat_sub64(mul_res, d_leaf_reg);
                OP_IN_BRANCH:   d_branch_reg   <= sat_sub64(mul_res, d_branch_reg);
                OP_IN_STEM:     d_stem_reg     <= sat_sub64(mul_res, d_stem_reg);
                OP_IN_ROOT:     d_root_reg     <= sat_sub64(mul_res, d_root_reg);
                OP_HUMIFY:      d_humus_reg    <= sat_sub64(mul_res, humus_flow_reg);
                OP_CARBONIZE:   d_coal_reg     <= sat_sub64(mul_res, d_coal_reg);
                default:        ;
            endcase
        end
    end

    // Total of the pools, one pool per cycle.
    always_comb
    begin
        case (cmd.sum_idx)
            POOL_LEAF:   sum_pool = leaf_reg;
            POOL_BRANCH: sum_pool = branch_reg;
            POOL_STEM:   sum_pool = stem_reg;
            POOL_ROOT:   sum_pool = root_reg;
            POOL_LITTER: sum_pool = litter_reg;
            POOL_HUMUS:  sum_pool = humus_reg;
            POOL_COAL:   sum_pool = coal_reg;
            default:     sum_pool = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum_en)
            total_reg <= (cmd.sum_first ? '0 : total_reg)
                       + {{(TOTAL_W-POOL_W){sum_pool[POOL_W-1]}}, sum_pool};
    end

    // Output record, loaded when the previous one has been taken.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_step_reg   <= step_reg;
            out_leaf_reg   <= leaf_reg;
            out_branch_reg <= branch_reg;
            out_stem_reg   <= stem_reg;
            out_root_reg   <= root_reg;
            out_litter_reg <= litter_reg;
            out_humus_reg  <= humus_reg;
            out_coal_reg   <= coal_reg;
            out_total_reg  <= total_reg;
        end
    end

    assign step_number     = out_step_reg;
    assign leaf_carbon     = out_leaf_reg;
    assign branch_carbon   = out_branch_reg;
    assign stem_carbon     = out_stem_reg;
    assign root_carbon     = out_root_reg;
    assign litter_carbon   = out_litter_reg;
    assign humus_carbon    = out_humus_reg;
    assign charcoal_carbon = out_coal_reg;
    assign total_carbon    = out_total_reg;

endmodule

[rtl/cces_ctrl.sv]
// ============================================================================
// cces_ctrl: sequencer of the carbon compartment Euler step
// Accepts one input transfer at a time and steps the datapath through the
// twenty scaled products (none on a clear), the pool sum and the output load.
// ============================================================================
module cces_ctrl import cces_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  logic    clear_pools,
    output logic    out_valid,
    input  logic    out_stall,
    output dp_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_SUM  = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cnt_next = '0;
                    if (clear_pools)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_SUM;
                    end
                    else
                    begin
                        cmd.step_inc = 1'b1;
                        state_next   = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                // Each product is issued as its low half, then its high half; it is then
                // accumulated and written back, overlapping the next one.
                cmd.mul_en  = (cnt_reg < CNT_W'(2 * NUM_OPS));
                cmd.mul_hi  = cnt_reg[0];
                cmd.mul_op  = cnt_reg[CNT_W-1:1];
                cmd.acc_add = !cnt_reg[0] && (cnt_reg >= CNT_W'(2))
                              && (cnt_reg <= CNT_W'(2 * NUM_OPS));
                cmd.wb_en   = cnt_reg[0] && (cnt_reg >= CNT_W'(3));
                cmd.wb_op   = cnt_reg[CNT_W-1:1] - 1'b1;
                if (cnt_reg == CNT_W'(RUN_LAST))
                begin
                    cnt_next   = '0;
                    state_next = ST_SUM;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SUM:
            begin
                cmd.sum_en    = 1'b1;
                cmd.sum_first = (cnt_reg == '0);
                cmd.sum_idx   = cnt_reg[2:0];
                if (cnt_reg == CNT_W'(NUM_POOLS - 1))
                    state_next = ST_HOLD;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on load, dropped when the record is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    // A new record never overwrites one that is still waiting.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && out_stall))
        else $error("output record overwritten while stalled");

    // Output valid only rises right after a load.
    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.out_load))
        else $error("output valid rose without a load");

    // Write-backs only name operations of the schedule.
    a_wb_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wb_en |-> (cmd.wb_op < op_t'(NUM_OPS)))
        else $error("write-back operation out of range");

    // After an accepted item the block is busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted back to back");

endmodule

[rtl/carbon_compartment_euler_step.sv]
// ============================================================================
// carbon_compartment_euler_step: seven-pool carbon model, one Euler step
// Top level: joins the sequencer and the datapath.
// ============================================================================
// Usage:
// Each input transfer (in_valid/in_stall, payload clear_pools) is one tick.
// With clear_pools low the pools advance one forward-Euler step; with it high
// the pools and step count return to zero. Every tick yields one output
// transfer (out_valid/out_stall) with the step count, the seven pools and
// their total. Coefficients are written through cfg_write/cfg_index/cfg_data
// and must be written only while the block is idle, which the block itself
// does not enforce; they take effect on the next tick. A step runs the 20
// products through the one shared 33x33 multiplier, then sums the seven
// pools and loads the output register; a clear skips the products. The next
// tick is accepted in the cycle after the output register is loaded.
// If the receiver stalls, the finished record waits in the output register
// and the following result waits in the pools until the record is taken.
// Reset clears the pools, the step count and all coefficient registers.
// ============================================================================
module carbon_compartment_euler_step import cces_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      clear_pools,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [COUNT_W-1:0]        step_number,
    output logic signed [POOL_W-1:0]  leaf_carbon,
    output logic signed [POOL_W-1:0]  branch_carbon,
    output logic signed [POOL_W-1:0]  stem_carbon,
    output logic signed [POOL_W-1:0]  root_carbon,
    output logic signed [POOL_W-1:0]  litter_carbon,
    output logic signed [POOL_W-1:0]  humus_carbon,
    output logic signed [POOL_W-1:0]  charcoal_carbon,
    output logic signed [TOTAL_W-1:0] total_carbon,
    input  logic                      cfg_write,
    input  cfg_idx_t                  cfg_index,
    input  logic [CFG_W-1:0]          cfg_data
);

    dp_cmd_t cmd;

    // Sequencer.
    cces_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .clear_pools (clear_pools),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cmd         (cmd)
    );

    // Arithmetic, state and output record.
    cces_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .step_number     (step_number),
        .leaf_carbon     (leaf_carbon),
        .branch_carbon   (branch_carbon),
        .stem_carbon     (stem_carbon),
        .root_carbon     (root_carbon),
        .litter_carbon   (litter_carbon),
        .humus_carbon    (humus_carbon),
        .charcoal_carbon (charcoal_carbon),
        .total_carbon    (total_carbon)
    );

endmodule
